FILE: src/rqps_pkg.sv
`default_nettype none
package rqps_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W = 4;
    localparam int KEY_W = 31;
    localparam int TICKET_W = 8;
    localparam int TOTAL_W = 12;
    localparam int RAND_W = 15;
    localparam logic [KEY_W-1:0] KEY_INFINITY = 31'd1000000000;

    typedef enum logic [1:0] {
        ACT_READY  = 2'd0,
        ACT_ASSIGN = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_PICK   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        POL_FCFS = 3'd0,
        POL_SJF = 3'd1,
        POL_PRIORITY = 3'd2,
        POL_RR = 3'd3,
        POL_LIFO = 3'd4,
        POL_HRRN = 3'd5,
        POL_SIF = 3'd6,
        POL_LOTT = 3'd7
    } policy_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_MOD,
        ST_SCAN,
        ST_OUT
    } state_t;

    // Token that accumulates the scan result while the slot contents rotate past the head cell.
    typedef struct packed {
        logic             found;
        logic [SLOT_W-1:0] idx;
        logic [KEY_W-1:0]  best;
        logic [TOTAL_W-1:0] run;
    } token_t;

endpackage
`default_nettype wire

FILE: src/ready_queue_priority_scheduler.sv
`default_nettype none
// Ready-queue scheduler over sixteen process slots.
// Input channel s_axis_*: one transaction per action (mark ready, assign
// key, remove, pick). Output channel m_axis_*: exactly one result
// transaction per input transaction, carrying chosen_slot, found and error.
// Configuration channel cfg_*: writes the 3-bit policy; write it only while
// the block is idle.
// The slots live in a ring of cells. A pick rotates the ring one full turn
// while a token accumulates the best key or the ticket sum. A lottery pick
// turns twice, with a restoring divide in between for the modulo. HRRN key
// assignment uses the same divider.
// One action is in flight at a time; the next is taken in the cycle after
// the result has been delivered.
// Reset empties all slots and sets the policy to FCFS. When the receiver
// stalls, the result is held in the output register and no new action is
// taken until it has been delivered.
module ready_queue_priority_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata from bit 0: action[1:0], slot_id[3:0], time_now[15:0],
    // remaining_burst[15:0], aging_boost[15:0], base_priority[7:0],
    // wait_time[15:0], burst_length[15:0], io_left[15:0],
    // ticket_count[7:0], random_value[14:0], zero fill to 152 bits.
    input  wire logic [151:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata from bit 0: chosen_slot[3:0], found, error, zero fill.
    output logic [7:0]       m_axis_tdata
);
    import rqps_pkg::*;

    logic [2:0] method_reg;
    state_t state_reg, state_next;

    // Latched action fields.
    logic [1:0]  act_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [RAND_W-1:0] rnd_reg;

    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    token_t tok_reg, tok_next;
    logic [TOTAL_W-1:0] target_reg;
    logic lott_pass_reg;

    logic [SLOT_W-1:0] out_slot_reg;
    logic out_found_reg, out_err_reg;
    logic out_valid_reg;

    // Field views of the incoming item.
    logic [1:0] in_act;
    logic [3:0] in_slot;
    logic [15:0] in_now, in_rem, in_age, in_wt, in_bl, in_io;
    logic [7:0] in_pri, in_tk;
    logic [14:0] in_rnd;
    assign in_act  = s_axis_tdata[1:0];
    assign in_slot = s_axis_tdata[5:2];
    assign in_now  = s_axis_tdata[21:6];
    assign in_rem  = s_axis_tdata[37:22];
    assign in_age  = s_axis_tdata[53:38];
    assign in_pri  = s_axis_tdata[61:54];
    assign in_wt   = s_axis_tdata[77:62];
    assign in_bl   = s_axis_tdata[93:78];
    assign in_io   = s_axis_tdata[109:94];
    assign in_tk   = s_axis_tdata[117:110];
    assign in_rnd  = s_axis_tdata[132:118];

    logic in_fire;
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    // Ring of cells.
    logic [NUM_SLOTS-1:0] c_rdy;
    logic [KEY_W-1:0] c_key [NUM_SLOTS];
    logic [TICKET_W-1:0] c_tk [NUM_SLOTS];
    logic shift;
    logic [NUM_SLOTS-1:0] wr_ready, wr_clear, wr_key;
    logic [KEY_W-1:0] key_w;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            rqps_cell u_cell (
                .clk(clk), .rst_n(rst_n), .shift(shift),
                .wr_ready(wr_ready[g]), .wr_clear(wr_clear[g]), .wr_key(wr_key[g]),
                .key_in_w(key_w), .tk_in_w(in_tk),
                .prev_rdy(c_rdy[(g + 1) % NUM_SLOTS]),
                .prev_key(c_key[(g + 1) % NUM_SLOTS]),
                .prev_tk(c_tk[(g + 1) % NUM_SLOTS]),
                .rdy(c_rdy[g]), .key(c_key[g]), .tk(c_tk[g])
            );
        end
    endgenerate

    // Divider shared by HRRN ratio and the lottery modulo.
    logic div_start, div_done;
    logic [16:0] div_a, div_q;
    logic [15:0] div_b, div_r;
    rqps_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    // Direct key computation for the non-dividing policies.
    logic [KEY_W-1:0] key_direct;
    always_comb
    begin
        unique case (policy_t'(method_reg))
            POL_SJF:      key_direct = (in_rem > in_age) ? KEY_W'(in_rem - in_age) : '0;
            POL_PRIORITY: key_direct = ({8'd0, in_pri} > in_age)
                                       ? KEY_W'({8'd0, in_pri} - in_age) : '0;
            POL_LIFO:     key_direct = KEY_INFINITY - KEY_W'(in_now);
            POL_SIF:      key_direct = KEY_W'(in_io);
            default:      key_direct = KEY_W'(in_now);
        endcase
    end

    logic assign_err;
    assign assign_err = !c_rdy[in_slot] || (in_bl == 16'd0);

    // Quotient from (wt + bl) / bl rounded up: add one if remainder nonzero.
    logic [KEY_W-1:0] hrrn_key;
    assign hrrn_key = KEY_INFINITY - KEY_W'(div_q) - KEY_W'(div_r != 16'd0);

    // Total fits 12 bits; remainder of 15-bit random by total.
    logic [TOTAL_W-1:0] lott_target;
    assign lott_target = TOTAL_W'(div_r) + TOTAL_W'(1);

    // Head cell of the ring carries the original slot index cnt_reg.
    logic [TOTAL_W-1:0] run_add;
    assign run_add = tok_reg.run + TOTAL_W'(c_tk[0]);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        tok_next = tok_reg;
        shift = 1'b0;
        wr_ready = '0;
        wr_clear = '0;
        wr_key = '0;
        key_w = key_direct;
        div_start = 1'b0;
        div_a = {1'b0, in_wt} + {1'b0, in_bl};
        div_b = in_bl;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    tok_next = '0;
                    tok_next.best = KEY_INFINITY;
                    cnt_next = '0;
                    unique case (action_t'(in_act))
                        ACT_READY:  begin wr_ready[in_slot] = 1'b1; state_next = ST_OUT; end
                        ACT_REMOVE: begin wr_clear[in_slot] = 1'b1; state_next = ST_OUT; end
                        ACT_ASSIGN:
                        begin
                            if (assign_err || method_reg == POL_LOTT)
                                state_next = ST_OUT;
                            else if (method_reg == POL_HRRN)
                            begin
                                div_start = 1'b1;
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                wr_key[in_slot] = 1'b1;
                                state_next = ST_OUT;
                            end
                        end
                        default:
                            state_next = (method_reg == POL_LOTT) ? ST_SUM : ST_SCAN;
                    endcase
                end
            end
            ST_DIV:
            begin
                key_w = hrrn_key;
                if (div_done)
                begin
                    wr_key[slot_reg] = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_SUM:
            begin
                shift = 1'b1;
                if (c_rdy[0])
                    tok_next.run = run_add;
                cnt_next = cnt_reg + SLOT_W'(1);
                if (cnt_reg == SLOT_W'(NUM_SLOTS - 1))
                begin
                    div_a = {2'b00, rnd_reg};
                    div_b = 16'(run_add & {TOTAL_W{c_rdy[0]}} |
                                tok_reg.run & {TOTAL_W{!c_rdy[0]}});
                    if (tok_next.run == '0)
                        state_next = ST_OUT;
                    else
                    begin
                        div_b = 16'(tok_next.run);
                        div_start = 1'b1;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                tok_next.run = '0;
                if (div_done)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                shift = 1'b1;
                cnt_next = cnt_reg + SLOT_W'(1);
                if (lott_pass_reg)
                begin
                    if (c_rdy[0] && !tok_reg.found)
                    begin
                        tok_next.run = run_add;
                        if (run_add >= target_reg)
                        begin
                            tok_next.found = 1'b1;
                            tok_next.idx = cnt_reg;
                        end
                    end
                end
                else if (c_rdy[0] && c_key[0] < tok_reg.best)
                begin
                    tok_next.best = c_key[0];
                    tok_next.idx = cnt_reg;
                    tok_next.found = 1'b1;
                end
                if (cnt_reg == SLOT_W'(NUM_SLOTS - 1))
                    state_next = ST_OUT;
            end
            default:
            begin
                if (!out_valid_reg)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            method_reg <= POL_FCFS;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
            lott_pass_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (cfg_valid && cfg_ready)
                method_reg <= cfg_data;
            if (in_fire)
                lott_pass_reg <= (in_act == ACT_PICK) && (method_reg == POL_LOTT);
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            else if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (in_fire)
        begin
            act_reg <= in_act;
            slot_reg <= in_slot;
            rnd_reg <= in_rnd;
            out_err_reg <= (in_act == ACT_ASSIGN) && assign_err;
        end
        if (state_reg == ST_MOD && div_done)
            target_reg <= lott_target;
        if (state_reg == ST_OUT && !out_valid_reg)
        begin
            out_found_reg <= (act_reg == ACT_PICK) && tok_reg.found;
            out_slot_reg <= ((act_reg == ACT_PICK) && tok_reg.found) ? tok_reg.idx : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {2'b00, out_err_reg, out_found_reg, out_slot_reg};
endmodule
`default_nettype wire

FILE: src/rqps_cell.sv
`default_nettype none
// One slot: ready flag, key and tickets. During a scan the contents rotate
// through the ring of cells, so every cell shifts its contents to the next.
module rqps_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         shift,
    input  wire logic                         wr_ready,
    input  wire logic                         wr_clear,
    input  wire logic                         wr_key,
    input  wire logic [rqps_pkg::KEY_W-1:0]   key_in_w,
    input  wire logic [rqps_pkg::TICKET_W-1:0] tk_in_w,
    input  wire logic                         prev_rdy,
    input  wire logic [rqps_pkg::KEY_W-1:0]   prev_key,
    input  wire logic [rqps_pkg::TICKET_W-1:0] prev_tk,
    output logic                              rdy,
    output logic [rqps_pkg::KEY_W-1:0]        key,
    output logic [rqps_pkg::TICKET_W-1:0]     tk
);
    import rqps_pkg::*;

    logic rdy_reg;
    logic [TICKET_W-1:0] tk_reg;
    logic [KEY_W-1:0] key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdy_reg <= 1'b0;
            tk_reg  <= '0;
        end
        else if (shift)
        begin
            rdy_reg <= prev_rdy;
            tk_reg  <= prev_tk;
        end
        else if (wr_ready)
        begin
            rdy_reg <= 1'b1;
            tk_reg  <= tk_in_w;
        end
        else if (wr_clear)
        begin
            rdy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
            key_reg <= prev_key;
        else if (wr_key)
            key_reg <= key_in_w;
    end

    assign rdy = rdy_reg;
    assign key = key_reg;
    assign tk  = tk_reg;
endmodule
`default_nettype wire

FILE: src/rqps_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle; returns quotient and remainder.
module rqps_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [16:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [16:0]      quotient,
    output logic [15:0]      remainder
);
    import rqps_pkg::*;

    logic [16:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [17:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg, q_reg[16]};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            cnt_next = 5'd17;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {2'b00, d_reg})
            begin
                r_next = 17'(trial - {2'b00, d_reg});
                q_next = {q_reg[15:0], 1'b1};
            end
            else
            begin
                r_next = trial[16:0];
                q_next = {q_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= divisor;
    end

    assign done = busy_reg && (cnt_reg == 5'd1);
    assign quotient = q_next;
    assign remainder = r_next[15:0];
endmodule
`default_nettype wire

FILE: src/rqps_checker.sv
`default_nettype none
module rqps_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);
    // A result never claims both a found slot and an error.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[5]))
        else $error("found and error both set");

    // Without a found slot the slot field reads zero.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[4]) |-> (m_axis_tdata[3:0] == 4'd0))
        else $error("slot nonzero without found");

    // No input is taken while a result waits.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed under stall");
endmodule

bind ready_queue_priority_scheduler rqps_checker u_rqps_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
